// ===== src/stk_pkg.sv =====
package stk_pkg;

	localparam int unsigned PageBytes = 1024;
	localparam int unsigned MaxPageHalfwords = 256;
	localparam int unsigned DataLimit = 2 * MaxPageHalfwords;
	localparam int unsigned PageBits = $clog2(PageBytes);

	localparam logic [7:0] CMD_GET_PARAM   = 8'h41;
	localparam logic [7:0] CMD_SET_DEV     = 8'h42;
	localparam logic [7:0] CMD_SET_DEV_EXT = 8'h45;
	localparam logic [7:0] CMD_LOAD_ADDR   = 8'h55;
	localparam logic [7:0] CMD_UNIVERSAL   = 8'h56;
	localparam logic [7:0] CMD_PROG_PAGE   = 8'h64;
	localparam logic [7:0] CMD_READ_PAGE   = 8'h74;
	localparam logic [7:0] CMD_READ_SIGN   = 8'h75;

	localparam logic [7:0] BYTE_INSYNC = 8'h14;
	localparam logic [7:0] BYTE_OK     = 8'h10;
	localparam logic [7:0] BYTE_EOP    = 8'h20;
	localparam logic [7:0] PARAM_HW    = 8'h81;
	localparam logic [7:0] PARAM_SW    = 8'h82;

	localparam logic [1:0] OP_NONE  = 2'd0;
	localparam logic [1:0] OP_ERASE = 2'd1;
	localparam logic [1:0] OP_WRITE = 2'd2;
	localparam logic [1:0] OP_READ  = 2'd3;

	localparam logic [1:0] REG_IMAGE_BASE = 2'd0;
	localparam logic [1:0] REG_APP_START  = 2'd1;
	localparam logic [1:0] REG_FLASH_END  = 2'd2;
	localparam logic [1:0] REG_SIGNATURE  = 2'd3;

	typedef enum logic [3:0] {
		PH_IDLE, PH_PARAM, PH_SKIP, PH_ADDR_LO, PH_ADDR_HI, PH_LEN_HI,
		PH_LEN_LO, PH_MEMTYPE, PH_DATA, PH_EOP, PH_RDWAIT
	} phase_t;

	// job kinds handed from the parser to the emitter
	typedef enum logic [2:0] {
		JOB_WRITE, JOB_ERASE, JOB_END, JOB_READ_FIRST, JOB_READ_DATA
	} job_kind_t;

	// one queued job: everything the emitter needs to produce its results
	typedef struct packed {
		job_kind_t   kind;
		logic [31:0] addr;
		logic [15:0] halfword;
		logic        ok;
		logic [7:0]  cmd;
		logic [7:0]  param;
		logic [23:0] sig;
		logic [7:0]  data;
		logic        more;
		logic        in_sync;
	} job_t;

	typedef struct packed {
		logic        tx_valid;
		logic [7:0]  tx_byte;
		logic [1:0]  flash_op;
		logic [31:0] flash_addr;
		logic [15:0] flash_halfword;
		logic        last;
	} result_t;

	typedef struct packed {
		logic [31:0] image_base;
		logic [31:0] app_start;
		logic [31:0] flash_end;
		logic [23:0] signature_bytes;
	} cfg_t;

endpackage

// ===== src/stk_if.sv =====
interface stk_in_if;
	logic       valid;
	logic       ready;
	logic       func;
	logic [7:0] rx_byte;
	logic [7:0] read_byte;
	modport source (output valid, func, rx_byte, read_byte, input ready);
	modport sink (input valid, func, rx_byte, read_byte, output ready);
endinterface

interface stk_out_if;
	logic        valid;
	logic        ready;
	logic        tx_valid;
	logic [7:0]  tx_byte;
	logic [1:0]  flash_op;
	logic [31:0] flash_addr;
	logic [15:0] flash_halfword;
	logic        last;
	modport source (output valid, tx_valid, tx_byte, flash_op, flash_addr, flash_halfword,
		last, input ready);
	modport sink (input valid, tx_valid, tx_byte, flash_op, flash_addr, flash_halfword,
		last, output ready);
endinterface

// ===== src/stk_cfg_regs.sv =====
module stk_cfg_regs (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [3:0]       paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	output stk_pkg::cfg_t    cfg
);
	import stk_pkg::*;

	cfg_t       cfg_q;
	logic [1:0] idx;
	logic       wr;

	assign idx = paddr[3:2];
	assign wr = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_base <= 32'd134217728;
			cfg_q.app_start <= 32'd134221824;
			cfg_q.flash_end <= 32'd134348800;
			cfg_q.signature_bytes <= 24'd2004239;
		end else if (wr) begin
			unique case (idx)
				REG_IMAGE_BASE: cfg_q.image_base <= pwdata;
				REG_APP_START:  cfg_q.app_start <= pwdata;
				REG_FLASH_END:  cfg_q.flash_end <= pwdata;
				REG_SIGNATURE:  cfg_q.signature_bytes <= pwdata[23:0];
			endcase
		end
	end

	// register reads
	always_comb begin
		unique case (idx)
			REG_IMAGE_BASE: prdata = cfg_q.image_base;
			REG_APP_START:  prdata = cfg_q.app_start;
			REG_FLASH_END:  prdata = cfg_q.flash_end;
			REG_SIGNATURE:  prdata = {8'd0, cfg_q.signature_bytes};
		endcase
	end
endmodule

// ===== src/stk_parser.sv =====
module stk_parser (
	input  logic          clk,
	input  logic          arst_n,
	stk_in_if.sink        in_ch,
	input  stk_pkg::cfg_t cfg,
	input  logic          q_ready,
	output logic          q_valid,
	output stk_pkg::job_t q_job
);
	import stk_pkg::*;

	phase_t      phase_q, phase_d;
	logic [7:0]  cmd_q, cmd_d;
	logic [15:0] cnt_q, cnt_d;
	logic [15:0] len_q, len_d;
	logic [15:0] waddr_q, waddr_d;
	logic [7:0]  held_q, held_d;
	logic [7:0]  param_q, param_d;
	logic        sync_q, sync_d;
	logic        wa_q, wa_d;
	logic        fire;
	logic [7:0]  rx;
	logic [31:0] page_addr;
	logic [15:0] cnt_inc;
	logic        wa_new;

	assign in_ch.ready = q_ready;
	assign fire = in_ch.valid & q_ready;
	assign rx = in_ch.rx_byte;
	assign page_addr = cfg.image_base + {15'd0, waddr_q, 1'b0};
	assign cnt_inc = cnt_q + 16'd1;
	assign wa_new = (page_addr < cfg.flash_end) && (page_addr >= cfg.app_start);

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			cmd_q <= '0;
			cnt_q <= '0;
			len_q <= '0;
			waddr_q <= '0;
			held_q <= '0;
			param_q <= '0;
			sync_q <= 1'b0;
			wa_q <= 1'b0;
		end else if (fire) begin
			phase_q <= phase_d;
			cmd_q <= cmd_d;
			cnt_q <= cnt_d;
			len_q <= len_d;
			waddr_q <= waddr_d;
			held_q <= held_d;
			param_q <= param_d;
			sync_q <= sync_d;
			wa_q <= wa_d;
		end
	end

	// classify one beat and build a job
	always_comb begin
		phase_d = phase_q;
		cmd_d = cmd_q;
		cnt_d = cnt_q;
		len_d = len_q;
		waddr_d = waddr_q;
		held_d = held_q;
		param_d = param_q;
		sync_d = sync_q;
		wa_d = wa_q;
		q_valid = 1'b0;
		q_job = '0;
		q_job.kind = JOB_WRITE;
		q_job.cmd = cmd_q;
		q_job.param = param_q;
		q_job.sig = cfg.signature_bytes;
		if (phase_q == PH_RDWAIT) begin
			if (in_ch.func) begin
				cnt_d = cnt_inc;
				q_valid = fire;
				q_job.kind = JOB_READ_DATA;
				q_job.data = in_ch.read_byte;
				q_job.in_sync = sync_q;
				q_job.more = (cnt_inc != len_q);
				q_job.addr = page_addr + {16'd0, cnt_inc};
				if (cnt_inc == len_q) phase_d = PH_IDLE;
			end
		end else if (!in_ch.func) begin
			unique case (phase_q)
				PH_PARAM: begin
					param_d = rx;
					phase_d = PH_EOP;
				end
				PH_SKIP: begin
					cnt_d = cnt_q - 16'd1;
					if (cnt_q == 16'd1) phase_d = PH_EOP;
				end
				PH_ADDR_LO: begin
					held_d = rx;
					phase_d = PH_ADDR_HI;
				end
				PH_ADDR_HI: begin
					waddr_d = {rx, held_q};
					phase_d = PH_EOP;
				end
				PH_LEN_HI: begin
					len_d = {rx, 8'd0};
					phase_d = PH_LEN_LO;
				end
				PH_LEN_LO: begin
					len_d = {len_q[15:8], rx};
					phase_d = PH_MEMTYPE;
				end
				PH_MEMTYPE: begin
					cnt_d = '0;
					if (cmd_q == CMD_PROG_PAGE) begin
						wa_d = wa_new;
						if (wa_new && page_addr[PageBits-1:0] == '0) begin
							q_valid = fire;
							q_job.kind = JOB_ERASE;
							q_job.addr = page_addr;
						end
						phase_d = (len_q == 16'd0) ? PH_EOP : PH_DATA;
					end else begin
						phase_d = PH_EOP;
					end
				end
				PH_DATA: begin
					if ({16'd0, cnt_q} < 32'(DataLimit)) begin
						if (!cnt_q[0]) begin
							held_d = rx;
							if (cnt_inc == len_q && wa_q) begin
								q_valid = fire;
								q_job.addr = page_addr + {16'd0, cnt_q};
								q_job.halfword = {8'hFF, rx};
							end
						end else if (wa_q) begin
							q_valid = fire;
							q_job.addr = page_addr + {16'd0, cnt_q - 16'd1};
							q_job.halfword = {rx, held_q};
						end
					end
					cnt_d = cnt_inc;
					if (cnt_inc == len_q) phase_d = PH_EOP;
				end
				PH_EOP: begin
					sync_d = (rx == BYTE_EOP);
					phase_d = PH_IDLE;
					q_valid = fire;
					q_job.kind = JOB_END;
					q_job.ok = (rx == BYTE_EOP);
					q_job.addr = page_addr;
					if (cmd_q == CMD_READ_PAGE && len_q != 16'd0) begin
						cnt_d = '0;
						phase_d = PH_RDWAIT;
						q_job.kind = JOB_READ_FIRST;
					end
				end
				default: begin
					cmd_d = rx;
					unique case (rx)
						CMD_GET_PARAM: phase_d = PH_PARAM;
						CMD_SET_DEV: begin
							cnt_d = 16'd20;
							phase_d = PH_SKIP;
						end
						CMD_SET_DEV_EXT: begin
							cnt_d = 16'd5;
							phase_d = PH_SKIP;
						end
						CMD_UNIVERSAL: begin
							cnt_d = 16'd4;
							phase_d = PH_SKIP;
						end
						CMD_LOAD_ADDR: phase_d = PH_ADDR_LO;
						CMD_PROG_PAGE, CMD_READ_PAGE: phase_d = PH_LEN_HI;
						default: phase_d = PH_EOP;
					endcase
				end
			endcase
		end
	end
endmodule

// ===== src/stk_job_fifo.sv =====
module stk_job_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_valid,
	output logic          wr_ready,
	input  stk_pkg::job_t wr_job,
	output logic          rd_valid,
	input  logic          rd_ready,
	output stk_pkg::job_t rd_job
);
	import stk_pkg::*;

	job_t       mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       do_wr, do_rd;

	assign wr_ready = (cnt_q != 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_job = mem_q[rp_q];
	assign do_wr = wr_valid & wr_ready;
	assign do_rd = rd_valid & rd_ready;

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (do_wr) wp_q <= ~wp_q;
			if (do_rd) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, do_wr} - {1'b0, do_rd};
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wp_q] <= wr_job;
	end
endmodule

// ===== src/stk_emitter.sv =====
module stk_emitter (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          j_valid,
	output logic          j_ready,
	input  stk_pkg::job_t job,
	stk_out_if.source     out_ch
);
	import stk_pkg::*;

	logic [2:0] idx_q;
	logic [2:0] n;
	result_t    r;
	result_t    res_q;
	logic       val_q;
	logic       take;
	logic       is_last;
	logic [7:0] tx [5];
	logic [7:0] reply;

	// reply byte for get parameter
	always_comb begin
		priority if (job.param == PARAM_SW) reply = 8'd5;
		else if (job.param == PARAM_HW) reply = 8'd4;
		else reply = 8'h03;
	end

	// build the result list of the head job
	always_comb begin
		for (int i = 0; i < 5; i++) tx[i] = '0;
		n = 3'd1;
		r = '0;
		unique case (job.kind)
			JOB_WRITE: begin
				r.flash_op = OP_WRITE;
				r.flash_addr = job.addr;
				r.flash_halfword = job.halfword;
			end
			JOB_ERASE: begin
				r.flash_op = OP_ERASE;
				r.flash_addr = job.addr;
			end
			JOB_READ_DATA: begin
				n = (job.more || job.in_sync) ? 3'd2 : 3'd1;
				r.tx_valid = (idx_q == 3'd0) || !job.more;
				r.tx_byte = (idx_q == 3'd0) ? job.data : (job.more ? 8'h00 : BYTE_OK);
				if (idx_q != 3'd0 && job.more) begin
					r.flash_op = OP_READ;
					r.flash_addr = job.addr;
				end
			end
			JOB_END, JOB_READ_FIRST: begin
				// insync, command reply, then ok or the first read
				n = 3'd0;
				if (job.ok) begin
					tx[0] = BYTE_INSYNC;
					n = 3'd1;
				end
				if (job.cmd == CMD_GET_PARAM) begin
					tx[n] = reply;
					n = n + 3'd1;
				end else if (job.cmd == CMD_UNIVERSAL) begin
					tx[n] = 8'h00;
					n = n + 3'd1;
				end else if (job.cmd == CMD_READ_SIGN) begin
					tx[n] = job.sig[23:16];
					tx[n + 3'd1] = job.sig[15:8];
					tx[n + 3'd2] = job.sig[7:0];
					n = n + 3'd3;
				end
				if (job.kind == JOB_READ_FIRST) begin
					if (idx_q == n) begin
						r.flash_op = OP_READ;
						r.flash_addr = job.addr;
					end
					n = n + 3'd1;
				end else if (job.ok) begin
					tx[n] = BYTE_OK;
					n = n + 3'd1;
				end
				if (!(job.kind == JOB_READ_FIRST && idx_q == n - 3'd1)) begin
					r.tx_valid = 1'b1;
					r.tx_byte = tx[idx_q];
				end
			end
			default: r = '0;
		endcase
		is_last = (idx_q + 3'd1 >= n);
		r.last = is_last;
	end

	assign take = j_valid && (n != 3'd0) && (!val_q || out_ch.ready);
	// a job without results is dropped at once
	assign j_ready = j_valid && ((n == 3'd0) || (take && is_last));

	// result sequencing and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			val_q <= 1'b0;
		end else begin
			if (take) idx_q <= is_last ? 3'd0 : idx_q + 3'd1;
			if (take) val_q <= 1'b1;
			else if (out_ch.ready) val_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) res_q <= r;
	end

	assign out_ch.valid = val_q;
	assign out_ch.tx_valid = res_q.tx_valid;
	assign out_ch.tx_byte = res_q.tx_byte;
	assign out_ch.flash_op = res_q.flash_op;
	assign out_ch.flash_addr = res_q.flash_addr;
	assign out_ch.flash_halfword = res_q.flash_halfword;
	assign out_ch.last = res_q.last;
endmodule

// ===== src/stk500_command_engine_core.sv =====
// STK500 v1 command engine, device side.
// in_ch beats carry either a host UART byte (func 0) or a flash read byte
// (func 1); out_ch beats carry one action each: a reply byte, an erase, a
// halfword write or a byte read request, with last set on the final beat
// caused by an input beat. Stray beats are consumed without results.
// The parser takes one input beat per cycle while the queue has room and
// pushes at most one job into a two-entry queue; the emitter expands each job
// into zero to five output beats, one per cycle while the receiver is ready,
// through a registered output stage. An input beat's job is registered in the
// queue, then its first output beat in the output register. Throughput is one
// input beat per cycle while beats yield at most one result and out_ch is ready.
// Reset returns the parser to waiting for a command, not in sync, and loads
// the register defaults; no byte is sent at reset.
// When the receiver stalls, the output register holds, the queue fills and
// in_ch.ready drops until space frees up.
// Registers via APB: image_base 0x0, app_start 0x4, flash_end 0x8,
// signature_bytes 0xC.
module stk500_command_engine_core (
	input  logic        clk,
	input  logic        arst_n,
	stk_in_if.sink      in_ch,
	stk_out_if.source   out_ch,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import stk_pkg::*;

	cfg_t cfg;
	job_t pj, fj;
	logic pv, pr, fv, fr;

	stk_cfg_regs u_regs (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
	);

	stk_parser u_parser (
		.clk, .arst_n, .in_ch, .cfg, .q_ready(pr), .q_valid(pv), .q_job(pj)
	);

	stk_job_fifo u_fifo (
		.clk, .arst_n, .wr_valid(pv), .wr_ready(pr), .wr_job(pj),
		.rd_valid(fv), .rd_ready(fr), .rd_job(fj)
	);

	stk_emitter u_emit (
		.clk, .arst_n, .j_valid(fv), .j_ready(fr), .job(fj), .out_ch
	);
endmodule

// ===== dv/stk500_command_engine_core_tb.sv =====
module stk500_command_engine_core_tb;
	import stk_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	stk_in_if  in_ch ();
	stk_out_if out_ch ();

	stk500_command_engine_core i_dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// one input beat of the directed table
	typedef struct {
		logic       func;
		logic [7:0] rx;
		logic [7:0] rd;
		logic       fixed;
		logic [7:0] fixed_tx;
	} stim_t;

	// predictor state
	phase_t      ph;
	logic [7:0]  cmd_q;
	logic [15:0] cnt_q;
	logic [15:0] len_q;
	logic [15:0] waddr_q;
	logic [7:0]  low_q;
	logic [7:0]  param_q;
	logic        sync_q;
	logic        wr_ok_q;
	cfg_t        cfg;

	result_t beat_q[$];
	result_t step_res[$];
	int      errors;
	int      cycles;
	bit      rd_pending;

	initial begin
		clk = 1'b0;
	end
	always #5 clk = ~clk;

	// cycle limit watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 600000) begin
			$display("FAIL stk500_command_engine_core");
			$finish;
		end
	end

	function automatic void push_res(logic txv, logic [7:0] tx, logic [1:0] op,
		logic [31:0] a, logic [15:0] hw);
		result_t r;
		r.tx_valid = txv;
		r.tx_byte = tx;
		r.flash_op = op;
		r.flash_addr = a;
		r.flash_halfword = hw;
		r.last = 1'b0;
		if (step_res.size() < 5) step_res.push_back(r);
	endfunction

	// reply byte to the host
	function automatic void send_tx(logic [7:0] b);
		push_res(1'b1, b, OP_NONE, 32'd0, 16'd0);
	endfunction

	function automatic logic [31:0] page_addr();
		return cfg.image_base + {15'd0, waddr_q, 1'b0};
	endfunction

	function automatic void end_byte(logic [7:0] b);
		sync_q = (b == BYTE_EOP);
		if (sync_q) send_tx(BYTE_INSYNC);
		ph = PH_IDLE;
		case (cmd_q)
			CMD_GET_PARAM: begin
				if (param_q == PARAM_SW) send_tx(8'd5);
				else if (param_q == PARAM_HW) send_tx(8'd4);
				else send_tx(8'h03);
			end
			CMD_UNIVERSAL: send_tx(8'h00);
			CMD_READ_SIGN: begin
				send_tx(cfg.signature_bytes[23:16]);
				send_tx(cfg.signature_bytes[15:8]);
				send_tx(cfg.signature_bytes[7:0]);
			end
			CMD_READ_PAGE: begin
				if (len_q != 16'd0) begin
					cnt_q = 16'd0;
					push_res(1'b0, 8'd0, OP_READ, page_addr(), 16'd0);
					ph = PH_RDWAIT;
					return;
				end
			end
			default: ;
		endcase
		if (sync_q) send_tx(BYTE_OK);
	endfunction

	function automatic void data_byte(logic [7:0] b);
		logic [31:0] i;
		i = {16'd0, cnt_q};
		if (i < 32'(DataLimit)) begin
			if (!i[0]) begin
				low_q = b;
				if (i + 32'd1 == {16'd0, len_q} && wr_ok_q)
					push_res(1'b0, 8'd0, OP_WRITE, page_addr() + i, {8'hFF, b});
			end else if (wr_ok_q) begin
				push_res(1'b0, 8'd0, OP_WRITE, page_addr() + i - 32'd1, {b, low_q});
			end
		end
		cnt_q = cnt_q + 16'd1;
		if (cnt_q == len_q) ph = PH_EOP;
	endfunction

	// predicts the beats one input beat causes, appends them to beat_q
	function automatic void predict_engine(logic f, logic [7:0] rx, logic [7:0] rd);
		logic [31:0] a;
		step_res.delete();
		if (ph == PH_RDWAIT) begin
			if (f) begin
				send_tx(rd);
				cnt_q = cnt_q + 16'd1;
				if (cnt_q == len_q) begin
					if (sync_q) send_tx(BYTE_OK);
					ph = PH_IDLE;
				end else begin
					push_res(1'b0, 8'd0, OP_READ, page_addr() + {16'd0, cnt_q}, 16'd0);
				end
			end
		end else if (!f) begin
			case (ph)
				PH_PARAM: begin param_q = rx; ph = PH_EOP; end
				PH_SKIP: begin
					cnt_q = cnt_q - 16'd1;
					if (cnt_q == 16'd0) ph = PH_EOP;
				end
				PH_ADDR_LO: begin low_q = rx; ph = PH_ADDR_HI; end
				PH_ADDR_HI: begin waddr_q = {rx, low_q}; ph = PH_EOP; end
				PH_LEN_HI: begin len_q = {rx, 8'd0}; ph = PH_LEN_LO; end
				PH_LEN_LO: begin len_q[7:0] = rx; ph = PH_MEMTYPE; end
				PH_MEMTYPE: begin
					cnt_q = 16'd0;
					if (cmd_q == CMD_PROG_PAGE) begin
						a = page_addr();
						wr_ok_q = (a < cfg.flash_end) && (a >= cfg.app_start);
						if (wr_ok_q && a[PageBits-1:0] == '0)
							push_res(1'b0, 8'd0, OP_ERASE, a, 16'd0);
						ph = (len_q == 16'd0) ? PH_EOP : PH_DATA;
					end else begin
						ph = PH_EOP;
					end
				end
				PH_DATA: data_byte(rx);
				PH_EOP: end_byte(rx);
				default: begin
					cmd_q = rx;
					case (rx)
						CMD_GET_PARAM: ph = PH_PARAM;
						CMD_SET_DEV: begin cnt_q = 16'd20; ph = PH_SKIP; end
						CMD_SET_DEV_EXT: begin cnt_q = 16'd5; ph = PH_SKIP; end
						CMD_UNIVERSAL: begin cnt_q = 16'd4; ph = PH_SKIP; end
						CMD_LOAD_ADDR: ph = PH_ADDR_LO;
						CMD_PROG_PAGE, CMD_READ_PAGE: ph = PH_LEN_HI;
						default: ph = PH_EOP;
					endcase
				end
			endcase
		end
		if (step_res.size() > 0) step_res[step_res.size()-1].last = 1'b1;
		foreach (step_res[k]) beat_q.push_back(step_res[k]);
	endfunction

	// send one input beat after a random gap
	task automatic send_beat(logic f, logic [7:0] rx, logic [7:0] rd);
		int gap;
		gap = $urandom_range(0, 13) * int'($urandom_range(0, 3) != 0);
		if (gap != 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.func <= f;
		in_ch.rx_byte <= rx;
		in_ch.read_byte <= rd;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		predict_engine(f, rx, rd);
		rd_pending = (ph == PH_RDWAIT);
	endtask

	task automatic host_byte(logic [7:0] b);
		send_beat(1'b0, b, 8'($urandom));
	endtask

	// answer outstanding reads until the read page finishes
	task automatic serve_reads();
		while (ph == PH_RDWAIT) send_beat(1'b1, 8'($urandom), 8'($urandom));
	endtask

	task automatic wait_drain();
		in_ch.valid <= 1'b0;
		while (beat_q.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic reg_write(logic [1:0] idx, logic [31:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_IMAGE_BASE: cfg.image_base = v;
			REG_APP_START: cfg.app_start = v;
			REG_FLASH_END: cfg.flash_end = v;
			default: cfg.signature_bytes = v[23:0];
		endcase
		@(posedge clk);
	endtask

	// output side: random stall, compare each beat against the oldest expected
	initial begin
		result_t e;
		int stall;
		out_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (out_ch.valid && out_ch.ready) begin
				if (beat_q.size() == 0) begin
					$error("unexpected beat tx=%h op=%h", out_ch.tx_byte, out_ch.flash_op);
					errors++;
				end else begin
					e = beat_q.pop_front();
					if (out_ch.tx_valid !== e.tx_valid) begin
						$error("tx_valid exp %h got %h", e.tx_valid, out_ch.tx_valid); errors++;
					end
					if (out_ch.tx_byte !== e.tx_byte) begin
						$error("tx_byte exp %h got %h", e.tx_byte, out_ch.tx_byte); errors++;
					end
					if (out_ch.flash_op !== e.flash_op) begin
						$error("flash_op exp %h got %h", e.flash_op, out_ch.flash_op); errors++;
					end
					if (out_ch.flash_addr !== e.flash_addr) begin
						$error("flash_addr exp %h got %h", e.flash_addr, out_ch.flash_addr);
						errors++;
					end
					if (out_ch.flash_halfword !== e.flash_halfword) begin
						$error("flash_halfword exp %h got %h", e.flash_halfword,
							out_ch.flash_halfword);
						errors++;
					end
					if (out_ch.last !== e.last) begin
						$error("last exp %h got %h", e.last, out_ch.last); errors++;
					end
				end
				stall = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 13) : 0;
				if (stall != 0) begin
					out_ch.ready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
			out_ch.ready <= 1'b1;
		end
	end

	// random command, mostly well-formed, or a stray beat, with random content
	task automatic random_command();
		int kind;
		int n;
		logic [15:0] len;
		kind = $urandom_range(0, 11);
		case (kind)
			0: begin host_byte(CMD_GET_PARAM); host_byte(8'($urandom_range('h80, 'h83)));
				host_byte(BYTE_EOP); end
			1: begin host_byte(CMD_SET_DEV); repeat (20) host_byte(8'($urandom));
				host_byte(BYTE_EOP); end
			2: begin host_byte(CMD_SET_DEV_EXT); repeat (5) host_byte(8'($urandom));
				host_byte(BYTE_EOP); end
			3: begin host_byte(CMD_UNIVERSAL); repeat (4) host_byte(8'($urandom));
				host_byte(BYTE_EOP); end
			4, 5: begin host_byte(CMD_LOAD_ADDR);
				host_byte(($urandom_range(0, 1)) ? 8'h00 : 8'($urandom));
				host_byte(8'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 'h3F)));
				host_byte(BYTE_EOP); end
			6, 7: begin
				n = $urandom_range(0, 9);
				len = (n == 0) ? 16'd0 : 16'($urandom_range(1, 12));
				host_byte(CMD_PROG_PAGE); host_byte(len[15:8]); host_byte(len[7:0]);
				host_byte(8'h46);
				repeat (len) host_byte(8'($urandom));
				host_byte(($urandom_range(0, 7) == 0) ? 8'($urandom) : BYTE_EOP);
			end
			8, 9: begin
				len = 16'($urandom_range(0, 6));
				host_byte(CMD_READ_PAGE); host_byte(len[15:8]); host_byte(len[7:0]);
				host_byte(8'h46);
				host_byte(($urandom_range(0, 7) == 0) ? 8'($urandom) : BYTE_EOP);
				if ($urandom_range(0, 3) == 0) host_byte(8'($urandom));
				serve_reads();
			end
			10: begin host_byte(CMD_READ_SIGN);
				host_byte(($urandom_range(0, 5) == 0) ? 8'($urandom) : BYTE_EOP); end
			default: begin
				if ($urandom_range(0, 1)) send_beat(1'b1, 8'($urandom), 8'($urandom));
				else host_byte(8'($urandom));
			end
		endcase
	endtask

	stim_t dir_tab[$];

	initial begin
		int k;
		stim_t s;
		errors = 0;
		cycles = 0;
		arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		in_ch.valid = 1'b0; in_ch.func = 1'b0; in_ch.rx_byte = '0; in_ch.read_byte = '0;
		ph = PH_IDLE; cmd_q = '0; cnt_q = '0; len_q = '0; waddr_q = '0; low_q = '0;
		param_q = '0; sync_q = 1'b0; wr_ok_q = 1'b0;
		cfg.image_base = 32'd134217728; cfg.app_start = 32'd134221824;
		cfg.flash_end = 32'd134348800; cfg.signature_bytes = 24'd2004239;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: stray flash byte, get param sw/hw, signature, bad end byte
		dir_tab = '{
			'{1'b1, 8'h00, 8'hFF, 1'b0, 8'h00},
			'{1'b0, CMD_GET_PARAM, 8'h00, 1'b0, 8'h00},
			'{1'b0, PARAM_SW, 8'h00, 1'b0, 8'h00},
			'{1'b0, BYTE_EOP, 8'h00, 1'b0, 8'h00},
			'{1'b0, CMD_GET_PARAM, 8'h00, 1'b0, 8'h00},
			'{1'b0, PARAM_HW, 8'h00, 1'b0, 8'h00},
			'{1'b0, 8'hFF, 8'h00, 1'b1, 8'h04},
			'{1'b0, CMD_READ_SIGN, 8'h00, 1'b0, 8'h00},
			'{1'b0, BYTE_EOP, 8'h00, 1'b0, 8'h00},
			'{1'b0, 8'hFF, 8'h00, 1'b0, 8'h00},
			'{1'b0, BYTE_EOP, 8'h00, 1'b0, 8'h00},
			'{1'b0, CMD_UNIVERSAL, 8'h00, 1'b0, 8'h00},
			'{1'b0, 8'hFF, 8'h00, 1'b0, 8'h00},
			'{1'b0, 8'h00, 8'h00, 1'b0, 8'h00},
			'{1'b0, 8'hAA, 8'h00, 1'b0, 8'h00},
			'{1'b0, 8'h55, 8'h00, 1'b0, 8'h00},
			'{1'b0, BYTE_EOP, 8'h00, 1'b0, 8'h00},
			'{1'b0, CMD_LOAD_ADDR, 8'h00, 1'b0, 8'h00},
			'{1'b0, 8'h00, 8'h00, 1'b0, 8'h00},
			'{1'b0, 8'h08, 8'h00, 1'b0, 8'h00},
			'{1'b0, BYTE_EOP, 8'h00, 1'b0, 8'h00}
		};
		for (k = 0; k < dir_tab.size(); k++) begin
			s = dir_tab[k];
			send_beat(s.func, s.rx, s.rd);
			// rows with a typed-in reply byte: bad end byte gives only the reply
			if (s.fixed && (step_res.size() != 1 || step_res[0].tx_byte != s.fixed_tx)) begin
				$error("tx_byte exp %h got %h", s.fixed_tx,
					step_res.size() ? step_res[0].tx_byte : 8'hxx);
				errors++;
			end
		end
		// zero length page, odd page write with erase, read page
		host_byte(CMD_PROG_PAGE); host_byte(8'h00); host_byte(8'h00); host_byte(8'h46);
		host_byte(BYTE_EOP);
		host_byte(CMD_PROG_PAGE); host_byte(8'h00); host_byte(8'h03); host_byte(8'h46);
		repeat (3) host_byte(8'($urandom));
		host_byte(BYTE_EOP);
		host_byte(CMD_READ_PAGE); host_byte(8'h00); host_byte(8'h02); host_byte(8'h46);
		host_byte(BYTE_EOP); host_byte(8'h41); serve_reads();
		wait_drain();

		// random phases over several register settings
		for (k = 0; k < 5; k++) begin
			case (k)
				0: begin reg_write(REG_IMAGE_BASE, 32'h0800_0000);
					reg_write(REG_APP_START, 32'h0800_1000);
					reg_write(REG_FLASH_END, 32'h0802_0000);
					reg_write(REG_SIGNATURE, 32'h00FF_00AA); end
				1: begin reg_write(REG_IMAGE_BASE, 32'h0);
					reg_write(REG_APP_START, 32'h0);
					reg_write(REG_FLASH_END, 32'hFFFF_FFFF);
					reg_write(REG_SIGNATURE, 32'h0); end
				2: begin reg_write(REG_IMAGE_BASE, 32'hFFFF_FFFE);
					reg_write(REG_APP_START, 32'hFFFF_FFFF);
					reg_write(REG_FLASH_END, 32'h0);
					reg_write(REG_SIGNATURE, 32'h00FF_FFFF); end
				default: begin reg_write(REG_IMAGE_BASE, $urandom & 32'hFFFF_FC00);
					reg_write(REG_APP_START, $urandom_range(0, 1) ? 32'h0 : $urandom);
					reg_write(REG_FLASH_END, $urandom_range(0, 1) ? 32'hFFFF_FFFF : $urandom);
					reg_write(REG_SIGNATURE, $urandom); end
			endcase
			repeat (2) random_command();
			serve_reads();
			wait_drain();
		end
		in_ch.valid <= 1'b0;
		if (errors == 0) begin
			$display("PASS stk500_command_engine_core");
		end else begin
			$display("FAIL stk500_command_engine_core");
		end
		$finish;
	end
endmodule
